>>> design/led_matrix_text_scroller_top_defines.svh
// Assertion macros used by the text scroller top level.
`ifndef LED_MATRIX_TEXT_SCROLLER_TOP_DEFINES_SVH
`define LED_MATRIX_TEXT_SCROLLER_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LMTS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lmts assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define LMTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lmts assertion failed");

`endif

>>> design/lmts_pkg.sv
// Package with the types, constants and font table of the text scroller.
package lmts_pkg;

  localparam int unsigned LmtsRows     = 8;
  localparam int unsigned LmtsRowW     = 8;
  localparam int unsigned LmtsCntW     = 6;
  localparam int unsigned LmtsGlyphCnt = 21;

  localparam logic [7:0] FirstGlyph = 8'h41;
  localparam logic [7:0] LastGlyph  = 8'h55;

  typedef logic [LmtsRowW-1:0] row_t;
  typedef logic [3:0]          addr_t;
  typedef logic [2:0]          idx_t;
  typedef logic [LmtsCntW-1:0] cnt_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic load;
  } cell_ctrl_t;

  localparam row_t GlyphRom [LmtsGlyphCnt*8] = '{
    8'h00, 8'h1F, 8'h24, 8'h44, 8'h44, 8'h24, 8'h1F, 8'h00,
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h00, 8'h22, 8'h41, 8'h41, 8'h41, 8'h22, 8'h1C, 8'h00,
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h00, 8'h00, 8'h41, 8'h49, 8'h49, 8'h49, 8'h7F, 8'h00,
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h00, 8'h7F, 8'h08, 8'h08, 8'h08, 8'h08, 8'h7F, 8'h00,
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h00, 8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h7F, 8'h00,
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h00, 8'h1C, 8'h22, 8'h41, 8'h41, 8'h22, 8'h1C, 8'h00,
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
    8'h00, 8'h7E, 8'h01, 8'h01, 8'h01, 8'h01, 8'h7E, 8'h00
  };

  // Characters outside the font read as a blank glyph.
  function automatic row_t glyph_byte(logic [7:0] code, idx_t k);
    logic [4:0] off;
    logic [7:0] idx;
    off = 5'(code - FirstGlyph);
    idx = {off, k};
    if (code inside {[FirstGlyph:LastGlyph]}) begin
      return GlyphRom[idx];
    end
    return '0;
  endfunction

endpackage

>>> design/lmts_in_if.sv
// Input channel carrying one message character per transfer.
interface lmts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       message_start;

  modport source (output valid, output char_code, output message_start, input ready);
  modport sink   (input valid, input char_code, input message_start, output ready);
endinterface

>>> design/lmts_out_if.sv
// Output channel carrying one display register write per transfer.
interface lmts_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] reg_address;
  logic [7:0] row_value;
  logic       last_write;

  modport source (output valid, output reg_address, output row_value, output last_write,
                  input ready);
  modport sink   (input valid, input reg_address, input row_value, input last_write,
                  output ready);
endinterface

>>> design/lmts_cfg_if.sv
// Configuration write channel for the scroll direction register.
interface lmts_cfg_if;
  logic valid;
  logic ready;
  logic scroll_vertical;

  modport source (output valid, output scroll_vertical, input ready);
  modport sink   (input valid, input scroll_vertical, output ready);
endinterface

>>> design/led_matrix_text_scroller_top.sv
// Top level of the 8x8 LED matrix text scroller.
// Each accepted character produces 64 display register writes, one per cycle when the
// output side takes them, and no new character is accepted until all are issued.
// The frame lives in a ring of eight row cells that rotates by one row per write, but
// for the write of row index 7 in horizontal mode, which loads the glyph byte into cell 0;
// the row leaving cell 0 is shown and fed back, updated in vertical mode, into cell 7.
// A new character is taken in the cycle after the last write of the previous one
// is loaded into the output register.
module led_matrix_text_scroller_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  lmts_in_if.sink    in_i,
  lmts_cfg_if.sink   cfg_i,
  lmts_out_if.source out_o
);
  import lmts_pkg::*;
  `include "led_matrix_text_scroller_top_defines.svh"

  logic       vert_q;
  logic       busy_q;
  cnt_t       cnt_q;
  logic [7:0] char_q;
  logic       out_valid_q;
  addr_t      out_addr_q;
  row_t       out_row_q;
  logic       out_last_q;

  row_t       rows [LmtsRows];
  cell_ctrl_t ctrl [LmtsRows];

  idx_t       step, row_idx;
  logic       in_fire, adv, hlast, gbit;
  row_t       gbyte, fb;

  assign step    = cnt_q[5:3];
  assign row_idx = cnt_q[2:0];
  assign in_fire = in_i.valid && !busy_q;
  assign adv     = busy_q && (!out_valid_q || out_o.ready);
  assign gbyte   = glyph_byte(char_q, vert_q ? row_idx : ~step);
  assign gbit    = gbyte[~step];
  assign fb      = vert_q ? {rows[0][LmtsRowW-2:0], gbit} : rows[0];
  assign hlast   = !vert_q && (row_idx == idx_t'(LmtsRows - 1));

  for (genvar i = 0; i < LmtsRows; i++) begin : g_cell
    row_t nbr;
    if (i == LmtsRows - 1) begin : g_tail
      assign nbr = fb;
    end else begin : g_body
      assign nbr = rows[i+1];
    end
    assign ctrl[i] = '{clear: in_fire && in_i.message_start,
                       shift: adv && !hlast,
                       load:  (i == 0) && adv && hlast};
    lmts_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl[i]),
      .nbr_i  (nbr),
      .load_i (gbyte),
      .row_o  (rows[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_q      <= 1'b0;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        vert_q <= cfg_i.scroll_vertical;
      end
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (adv && (cnt_q == '1)) begin
        busy_q <= 1'b0;
      end
      if (adv) begin
        cnt_q       <= cnt_q + cnt_t'(1);
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      char_q <= in_i.char_code;
    end
    if (adv) begin
      out_addr_q <= {1'b0, row_idx} + addr_t'(1);
      out_row_q  <= fb;
      out_last_q <= (cnt_q == '1);
    end
  end

  assign in_i.ready        = !busy_q;
  assign cfg_i.ready       = 1'b1;
  assign out_o.valid       = out_valid_q;
  assign out_o.reg_address = out_addr_q;
  assign out_o.row_value   = out_row_q;
  assign out_o.last_write  = out_last_q;

  `LMTS_ASSERT_SAME(a_idle_count_zero, clk_i, rst_ni, !busy_q, cnt_q == '0)
  `LMTS_ASSERT_SAME(a_last_is_row8, clk_i, rst_ni, out_valid_q && out_last_q,
                    out_addr_q == addr_t'(LmtsRows))
  `LMTS_ASSERT_NEXT(a_start_clears, clk_i, rst_ni, in_fire && in_i.message_start,
                    rows[0] == '0 && rows[LmtsRows-1] == '0)

endmodule

>>> design/lmts_cell.sv
// One frame row cell of the rotating row chain.
module lmts_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lmts_pkg::cell_ctrl_t   ctrl_i,
  input  lmts_pkg::row_t         nbr_i,
  input  lmts_pkg::row_t         load_i,
  output lmts_pkg::row_t         row_o
);
  import lmts_pkg::*;

  row_t row_d, row_q;

  always_comb begin
    row_d = row_q;
    if (ctrl_i.clear) begin
      row_d = '0;
    end else if (ctrl_i.load) begin
      row_d = load_i;
    end else if (ctrl_i.shift) begin
      row_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule
